### src/kmer_bucket_table_builder_core_macros.svh
`ifndef KMER_BUCKET_TABLE_BUILDER_CORE_MACROS_SVH
`define KMER_BUCKET_TABLE_BUILDER_CORE_MACROS_SVH

// Same-cycle implication on aclk, off while in reset.
`define KBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kbt same-cycle check failed");

// Next-cycle implication on aclk, off while in reset.
`define KBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kbt next-cycle check failed");

`endif

### src/kbt_pkg.sv
package kbt_pkg;

    localparam int MAX_PREFIX_DEF = 12;
    localparam int INPUT_SYMBOLS  = 12;
    localparam int CODE_W         = 2 * INPUT_SYMBOLS;
    localparam int IDX_W          = CODE_W + 1;
    localparam int VALUE_W        = 32;
    localparam int LEN_W          = 4;

    localparam logic [LEN_W-1:0] LONG_LEN_RST  = 4'd12;
    localparam logic [LEN_W-1:0] SHORT_LEN_RST = 4'd8;

    typedef enum logic {
        REG_LONG_LEN  = 1'b0,
        REG_SHORT_LEN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic               long_valid;
        logic [IDX_W-1:0]   long_first;
        logic [IDX_W-1:0]   long_last;
        logic               short_valid;
        logic [IDX_W-1:0]   short_first;
        logic [IDX_W-1:0]   short_last;
        logic [VALUE_W-1:0] entry_value;
        logic               last_of_run;
        logic               order_error;
    } result_t;

endpackage

### src/kmer_bucket_table_builder_core.sv
// Channel  | Ports                                        | Direction
// s_       | s_valid/s_ready, s_prefix_symbols, s_is_last | in: one suffix array entry
// m_       | m_valid/m_ready, range and value fields      | out: one table fill result
// cfg_     | cfg_wr_en, cfg_index, cfg_data               | in: prefix length registers
//
// An entry is accepted in any cycle with room for two results in the 4-deep result queue.
// Each result is registered in the result queue before it appears on m_; a last entry yields two results.
// Sustained rate is one entry per cycle while m_ takes every result; the last entry of a stream adds a second result.
// aresetn is synchronous, active low: lengths return to 12 and 8, stream state and queue clear.
// An m_ stall backs up into the queue and then drops s_ready; nothing is lost.
`include "kmer_bucket_table_builder_core_macros.svh"

module kmer_bucket_table_builder_core
    import kbt_pkg::*;
#(
    parameter int MAX_PREFIX = MAX_PREFIX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [LEN_W-1:0]    cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CODE_W-1:0]   s_prefix_symbols,
    input  logic                s_is_last,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_long_valid,
    output logic [IDX_W-1:0]    m_long_first,
    output logic [IDX_W-1:0]    m_long_last,
    output logic                m_short_valid,
    output logic [IDX_W-1:0]    m_short_first,
    output logic [IDX_W-1:0]    m_short_last,
    output logic [VALUE_W-1:0]  m_entry_value,
    output logic                m_last_of_run,
    output logic                m_order_error
);

    localparam int CAP_INT = (MAX_PREFIX < INPUT_SYMBOLS) ? MAX_PREFIX : INPUT_SYMBOLS;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int SH_W  = LEN_W + 1;

    logic [LEN_W-1:0]   long_len_reg, short_len_reg;
    logic [CODE_W-1:0]  prev_code_reg;
    logic               seen_reg;
    logic [VALUE_W-1:0] rank_reg;

    result_t            fifo_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [LEN_W-1:0]   eff_long, eff_short;
    logic [SH_W-1:0]    sh;
    logic [IDX_W-1:0]   top;
    logic [CODE_W-1:0]  code;
    logic [IDX_W-1:0]   first;
    logic               err;
    logic               seen_upd;
    logic [CODE_W-1:0]  prev_upd;
    logic [IDX_W-1:0]   fill_first;
    logic [VALUE_W-1:0] rank_inc;
    result_t            res_main, res_fill;
    logic               accept, pop;
    logic [CNT_W-1:0]   push_n;

    function automatic result_t make_res(
        input logic [IDX_W-1:0]   rfirst,
        input logic [IDX_W-1:0]   rlast,
        input logic [SH_W-1:0]    rsh,
        input logic [VALUE_W-1:0] value,
        input logic               last_run,
        input logic               rerr
    );
        result_t          r;
        logic [IDX_W:0]   scale_m1;
        logic [IDX_W:0]   sf;
        logic [IDX_W:0]   sl;
        logic             lv;
        logic             sv;
        scale_m1 = ((IDX_W+1)'(1) << rsh) - (IDX_W+1)'(1);
        sf = ({1'b0, rfirst} + scale_m1) >> rsh;
        sl = {1'b0, rlast} >> rsh;
        lv = !rerr && (rfirst <= rlast);
        sv = lv && (sf <= sl);
        r.long_valid  = lv;
        r.long_first  = lv ? rfirst : '0;
        r.long_last   = lv ? rlast : '0;
        r.short_valid = sv;
        r.short_first = sv ? sf[IDX_W-1:0] : '0;
        r.short_last  = sv ? sl[IDX_W-1:0] : '0;
        r.entry_value = value;
        r.last_of_run = last_run;
        r.order_error = rerr;
        return r;
    endfunction

    // Clamp lengths: long to 1..cap, short to 1..long.
    always_comb begin
        if (long_len_reg == '0) begin
            eff_long = LEN_W'(1);
        end else if (long_len_reg > LEN_CAP) begin
            eff_long = LEN_CAP;
        end else begin
            eff_long = long_len_reg;
        end
        if (short_len_reg == '0) begin
            eff_short = LEN_W'(1);
        end else if (short_len_reg > eff_long) begin
            eff_short = eff_long;
        end else begin
            eff_short = short_len_reg;
        end
    end

    always_comb begin
        sh         = {eff_long - eff_short, 1'b0};
        top        = IDX_W'(1) << {eff_long, 1'b0};
        code       = s_prefix_symbols & CODE_W'(top - IDX_W'(1));
        first      = seen_reg ? ({1'b0, prev_code_reg} + IDX_W'(1)) : '0;
        err        = seen_reg && (code < prev_code_reg);
        seen_upd   = err ? seen_reg : 1'b1;
        prev_upd   = err ? prev_code_reg : code;
        fill_first = seen_upd ? ({1'b0, prev_upd} + IDX_W'(1)) : '0;
        rank_inc   = rank_reg + VALUE_W'(1);
        res_main   = make_res(first, {1'b0, code}, sh, rank_reg, !s_is_last, err);
        res_fill   = make_res(fill_first, top, sh, rank_inc, 1'b1, 1'b0);
    end

    assign s_ready = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign push_n  = accept ? (s_is_last ? CNT_W'(2) : CNT_W'(1)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_len_reg  <= LONG_LEN_RST;
            short_len_reg <= SHORT_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LONG_LEN:  long_len_reg  <= cfg_data;
                REG_SHORT_LEN: short_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg <= '0;
            seen_reg      <= 1'b0;
            rank_reg      <= VALUE_W'(1);
        end else if (accept) begin
            if (s_is_last) begin
                // End of stream: back to the reset state.
                prev_code_reg <= '0;
                seen_reg      <= 1'b0;
                rank_reg      <= VALUE_W'(1);
            end else begin
                prev_code_reg <= prev_upd;
                seen_reg      <= seen_upd;
                rank_reg      <= rank_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fifo_mem[wr_ptr_reg] <= res_main;
            if (s_is_last) begin
                fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res_fill;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n[PTR_W-1:0];
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + push_n - CNT_W'(pop);
        end
    end

    assign m_long_valid  = fifo_mem[rd_ptr_reg].long_valid;
    assign m_long_first  = fifo_mem[rd_ptr_reg].long_first;
    assign m_long_last   = fifo_mem[rd_ptr_reg].long_last;
    assign m_short_valid = fifo_mem[rd_ptr_reg].short_valid;
    assign m_short_first = fifo_mem[rd_ptr_reg].short_first;
    assign m_short_last  = fifo_mem[rd_ptr_reg].short_last;
    assign m_entry_value = fifo_mem[rd_ptr_reg].entry_value;
    assign m_last_of_run = fifo_mem[rd_ptr_reg].last_of_run;
    assign m_order_error = fifo_mem[rd_ptr_reg].order_error;

    `KBT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `KBT_ASSERT_NEXT(a_last_two, accept && s_is_last && !pop,
                     cnt_reg == $past(cnt_reg) + CNT_W'(2))
    `KBT_ASSERT_NEXT(a_stream_end, accept && s_is_last,
                     !seen_reg && rank_reg == VALUE_W'(1))
    `KBT_ASSERT_NOW(a_err_no_range, m_valid && m_order_error, !m_long_valid && !m_short_valid)

endmodule
